@@ rtl/core/midpoint_circle_pixel_generator_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef MIDPOINT_CIRCLE_PIXEL_GENERATOR_DEFINES_SVH
`define MIDPOINT_CIRCLE_PIXEL_GENERATOR_DEFINES_SVH

// Clocked assertion, ignored while reset is asserted.
`define MCPG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MCPG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mcpg_pkg.sv @@
package mcpg_pkg;

  // Window registers
  localparam int WIN_BITS = 13;
  localparam logic [WIN_BITS-1:0] WIN_WIDTH_RESET  = 13'd640;
  localparam logic [WIN_BITS-1:0] WIN_HEIGHT_RESET = 13'd480;

  localparam int COLOR_BITS = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_WINDOW_WIDTH  = 1'b0,
    REG_WINDOW_HEIGHT = 1'b1
  } reg_idx_t;

  // Points per group
  localparam int PT_IDX_BITS = 3;
  localparam logic [PT_IDX_BITS-1:0] LAST_POINT = 3'd7;

  // Midpoint decision update terms
  localparam int DEC_INIT    = 3;
  localparam int DEC_STEP_E  = 6;
  localparam int DEC_STEP_SE = 10;
  localparam int DEC_SHIFT   = 2;  // times four

  // Group handoff from stepper to point emitter
  typedef struct packed {
    logic valid;
    logic done;
  } grp_ctrl_t;

endpackage

@@ rtl/core/mcpg_stepper.sv @@
module mcpg_stepper #(
  parameter int COORD_BITS  = 13,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic                                  start_req,
  input  logic signed [COORD_BITS-1:0]          center_x,
  input  logic signed [COORD_BITS-1:0]          center_y,
  input  logic        [RADIUS_BITS-1:0]         radius,
  input  logic        [mcpg_pkg::COLOR_BITS-1:0] pen_color,
  output mcpg_pkg::grp_ctrl_t                   grp_ctrl,
  output logic signed [COORD_BITS-1:0]          grp_cx,
  output logic signed [COORD_BITS-1:0]          grp_cy,
  output logic signed [RADIUS_BITS+1:0]         grp_ox,
  output logic signed [RADIUS_BITS+1:0]         grp_oy,
  output logic        [mcpg_pkg::COLOR_BITS-1:0] grp_color
);

  localparam int OFF_BITS = RADIUS_BITS + 2;
  localparam int DEC_BITS = RADIUS_BITS + 6;

  logic                               busy;
  logic signed [COORD_BITS-1:0]       held_cx;
  logic signed [COORD_BITS-1:0]       held_cy;
  logic signed [OFF_BITS-1:0]         offset_x;
  logic signed [OFF_BITS-1:0]         offset_y;
  logic signed [DEC_BITS-1:0]         decision;
  logic [mcpg_pkg::COLOR_BITS-1:0]    held_color;

  logic signed [OFF_BITS-1:0]         src_x;
  logic signed [OFF_BITS-1:0]         src_y;
  logic signed [DEC_BITS-1:0]         src_d;
  logic signed [DEC_BITS-1:0]         dec_init;
  logic signed [OFF_BITS-1:0]         x_next;
  logic signed [OFF_BITS-1:0]         y_next;
  logic signed [DEC_BITS-1:0]         d_next;
  logic signed [DEC_BITS-1:0]         x1_e;
  logic signed [DEC_BITS-1:0]         y_e;
  logic signed [DEC_BITS-1:0]         diff_e;
  logic                               final_grp;

  assign dec_init = DEC_BITS'(mcpg_pkg::DEC_INIT)
                  - {{(DEC_BITS-RADIUS_BITS-1){1'b0}}, radius, 1'b0};

  always_comb begin
    src_x = start_req ? '0 : offset_x;
    src_y = start_req ? {{(OFF_BITS-RADIUS_BITS){1'b0}}, radius} : offset_y;
    src_d = start_req ? dec_init : decision;
  end

  // One midpoint step from the source offset
  always_comb begin
    x_next = src_x + OFF_BITS'(1);
    x1_e   = {{(DEC_BITS-OFF_BITS){x_next[OFF_BITS-1]}}, x_next};
    y_e    = {{(DEC_BITS-OFF_BITS){src_y[OFF_BITS-1]}}, src_y};
    diff_e = x1_e - y_e;
    if (src_d[DEC_BITS-1]) begin
      d_next = src_d + (x1_e <<< mcpg_pkg::DEC_SHIFT) + DEC_BITS'(mcpg_pkg::DEC_STEP_E);
      y_next = src_y;
    end else begin
      d_next = src_d + (diff_e <<< mcpg_pkg::DEC_SHIFT) + DEC_BITS'(mcpg_pkg::DEC_STEP_SE);
      y_next = src_y - OFF_BITS'(1);
    end
  end

  assign final_grp = !start_req && (src_x >= src_y);

  always_comb begin
    grp_ctrl.valid = accept && (start_req || busy);
    grp_ctrl.done  = final_grp;
    grp_cx    = start_req ? center_x  : held_cx;
    grp_cy    = start_req ? center_y  : held_cy;
    grp_color = start_req ? pen_color : held_color;
    grp_ox    = src_x;
    grp_oy    = src_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      if (start_req) begin
        busy       <= 1'b1;
        held_cx    <= center_x;
        held_cy    <= center_y;
        held_color <= pen_color;
        offset_x   <= x_next;
        offset_y   <= y_next;
        decision   <= d_next;
      end else if (busy) begin
        if (final_grp) begin
          busy <= 1'b0;
        end else begin
          offset_x <= x_next;
          offset_y <= y_next;
          decision <= d_next;
        end
      end
    end
  end

endmodule

@@ rtl/core/mcpg_emit.sv @@
module mcpg_emit #(
  parameter int COORD_BITS  = 13,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mcpg_pkg::grp_ctrl_t                   grp_ctrl,
  input  logic signed [COORD_BITS-1:0]          grp_cx,
  input  logic signed [COORD_BITS-1:0]          grp_cy,
  input  logic signed [RADIUS_BITS+1:0]         grp_ox,
  input  logic signed [RADIUS_BITS+1:0]         grp_oy,
  input  logic        [mcpg_pkg::COLOR_BITS-1:0] grp_color,
  output logic                                  grp_ready,
  input  logic [mcpg_pkg::WIN_BITS-1:0]         window_width,
  input  logic [mcpg_pkg::WIN_BITS-1:0]         window_height,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((2*(COORD_BITS+1)+mcpg_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  output logic                                  m_tlast,
  output logic [1:0]                            m_tuser
);

  localparam int OFF_BITS  = RADIUS_BITS + 2;
  localparam int PIX_BITS  = COORD_BITS + 1;
  localparam int WB        = mcpg_pkg::WIN_BITS;
  localparam int MAX1      = (COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS;
  localparam int MAX2      = (MAX1 > WB) ? MAX1 : WB;
  localparam int SUM_BITS  = MAX2 + 2;
  localparam int OUT_BITS  = ((2*PIX_BITS+mcpg_pkg::COLOR_BITS+7)/8)*8;
  localparam int PAD_BITS  = OUT_BITS - 2*PIX_BITS - mcpg_pkg::COLOR_BITS;

  logic                                    grp_valid;
  logic [mcpg_pkg::PT_IDX_BITS-1:0]        idx;
  logic signed [COORD_BITS-1:0]            g_cx;
  logic signed [COORD_BITS-1:0]            g_cy;
  logic signed [OFF_BITS-1:0]              g_ox;
  logic signed [OFF_BITS-1:0]              g_oy;
  logic [mcpg_pkg::COLOR_BITS-1:0]         g_color;
  logic                                    g_done;

  logic                                    out_adv;
  logic                                    pt_last;
  logic signed [SUM_BITS-1:0]              cx_e, cy_e, a_e, b_e, dx, dy, px, py;
  logic                                    vis;

  assign out_adv   = grp_valid && (!m_tvalid || m_tready);
  assign pt_last   = (idx == mcpg_pkg::LAST_POINT);
  assign grp_ready = !grp_valid || (out_adv && pt_last);

  // Point order: idx[2] swaps x/y offsets, idx[1] negates x, idx[0] negates y
  always_comb begin
    cx_e = {{(SUM_BITS-COORD_BITS){g_cx[COORD_BITS-1]}}, g_cx};
    cy_e = {{(SUM_BITS-COORD_BITS){g_cy[COORD_BITS-1]}}, g_cy};
    a_e  = {{(SUM_BITS-OFF_BITS){g_ox[OFF_BITS-1]}}, g_ox};
    b_e  = {{(SUM_BITS-OFF_BITS){g_oy[OFF_BITS-1]}}, g_oy};
    dx   = idx[2] ? b_e : a_e;
    dy   = idx[2] ? a_e : b_e;
    px   = idx[1] ? (cx_e - dx) : (cx_e + dx);
    py   = idx[0] ? (cy_e - dy) : (cy_e + dy);
    vis  = !px[SUM_BITS-1] && !py[SUM_BITS-1]
        && ($unsigned(px) < {{(SUM_BITS-WB){1'b0}}, window_width})
        && ($unsigned(py) < {{(SUM_BITS-WB){1'b0}}, window_height});
  end

  // Group register
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
    end else if (grp_ctrl.valid) begin
      grp_valid <= 1'b1;
      idx       <= '0;
      g_cx      <= grp_cx;
      g_cy      <= grp_cy;
      g_ox      <= grp_ox;
      g_oy      <= grp_oy;
      g_color   <= grp_color;
      g_done    <= grp_ctrl.done;
    end else if (out_adv) begin
      idx <= idx + mcpg_pkg::PT_IDX_BITS'(1);
      if (pt_last) begin
        grp_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      m_tdata <= {{PAD_BITS{1'b0}}, g_color, py[PIX_BITS-1:0], px[PIX_BITS-1:0]};
      m_tlast <= pt_last;
      m_tuser <= {g_done, vis};
    end
  end

endmodule

@@ rtl/core/midpoint_circle_pixel_generator.sv @@
// Channel  | Dir | Signals                              | Contents
// ---------+-----+--------------------------------------+---------------------------------
// s_       | in  | s_tvalid s_tready s_tdata s_tuser    | circle start or step item
// m_       | out | m_tvalid m_tready m_tdata m_tlast    | one mirrored point per transfer
//          |     | m_tuser                              |
// apb      | in  | psel penable pwrite paddr pwdata     | window_width @0, window_height @4
//          |     | prdata pready                        |
//
// Each start item, and each step item while a circle is active, yields eight
// point transfers, one per cycle while m_ is not stalled. A step item while
// idle yields nothing. The next item is taken as the eighth point enters the
// output register: no gap between groups.
// rst (synchronous) clears circle, group and output registers; window back to 640 x 480.
// A stall on m_ holds the output register and the group, and so stalls s_.
module midpoint_circle_pixel_generator #(
  parameter int COORD_BITS  = 13,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // APB configuration port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [mcpg_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  logic [mcpg_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic [mcpg_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                     pready,
  // item input
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // s_tdata, low bit up: center_x, center_y, radius, pen_color, zero pad
  input  logic [((2*COORD_BITS+RADIUS_BITS+mcpg_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: start_req
  input  logic [0:0]                               s_tuser,
  // point output
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // m_tdata, low bit up: pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*(COORD_BITS+1)+mcpg_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  // m_tlast: last point of the group
  output logic                                     m_tlast,
  // m_tuser, low bit up: visible, done_res
  output logic [1:0]                               m_tuser
);

  localparam int CB = COORD_BITS;
  localparam int RB = RADIUS_BITS;
  localparam int WB = mcpg_pkg::WIN_BITS;

  logic [WB-1:0]                      window_width;
  logic [WB-1:0]                      window_height;
  logic                               cfg_write;
  mcpg_pkg::reg_idx_t                 cfg_idx;

  logic                               accept;
  logic                               grp_ready;
  mcpg_pkg::grp_ctrl_t                grp_ctrl;
  logic signed [CB-1:0]               grp_cx;
  logic signed [CB-1:0]               grp_cy;
  logic signed [RB+1:0]               grp_ox;
  logic signed [RB+1:0]               grp_oy;
  logic [mcpg_pkg::COLOR_BITS-1:0]    grp_color;

  logic signed [CB-1:0]               in_cx;
  logic signed [CB-1:0]               in_cy;
  logic [RB-1:0]                      in_radius;
  logic [mcpg_pkg::COLOR_BITS-1:0]    in_color;

  // Configuration registers; the index is paddr[2]
  assign pready    = 1'b1;
  assign cfg_idx   = mcpg_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= mcpg_pkg::WIN_WIDTH_RESET;
      window_height <= mcpg_pkg::WIN_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        mcpg_pkg::REG_WINDOW_WIDTH:  window_width  <= pwdata[WB-1:0];
        mcpg_pkg::REG_WINDOW_HEIGHT: window_height <= pwdata[WB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mcpg_pkg::REG_WINDOW_WIDTH:
        prdata = {{(mcpg_pkg::APB_DATA_BITS-WB){1'b0}}, window_width};
      mcpg_pkg::REG_WINDOW_HEIGHT:
        prdata = {{(mcpg_pkg::APB_DATA_BITS-WB){1'b0}}, window_height};
      default:
        prdata = '0;
    endcase
  end

  // Input unpack
  assign in_cx     = s_tdata[CB-1:0];
  assign in_cy     = s_tdata[2*CB-1:CB];
  assign in_radius = s_tdata[2*CB+RB-1:2*CB];
  assign in_color  = s_tdata[2*CB+RB+mcpg_pkg::COLOR_BITS-1:2*CB+RB];

  // Items are taken whenever the group register is free for the next group
  assign s_tready = grp_ready;
  assign accept   = s_tvalid && s_tready;

  mcpg_stepper #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) u_stepper (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .start_req(s_tuser[0]),
    .center_x (in_cx),
    .center_y (in_cy),
    .radius   (in_radius),
    .pen_color(in_color),
    .grp_ctrl (grp_ctrl),
    .grp_cx   (grp_cx),
    .grp_cy   (grp_cy),
    .grp_ox   (grp_ox),
    .grp_oy   (grp_oy),
    .grp_color(grp_color)
  );

  mcpg_emit #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .grp_ctrl     (grp_ctrl),
    .grp_cx       (grp_cx),
    .grp_cy       (grp_cy),
    .grp_ox       (grp_ox),
    .grp_oy       (grp_oy),
    .grp_color    (grp_color),
    .grp_ready    (grp_ready),
    .window_width (window_width),
    .window_height(window_height),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

endmodule

@@ rtl/core/mcpg_checker.sv @@
`include "midpoint_circle_pixel_generator_defines.svh"

module mcpg_checker #(
  parameter int PIX_BITS      = 14,
  parameter int OUT_DATA_BITS = 48
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tlast,
  input logic [1:0]               m_tuser
);

  // stalled transfer holds
  `MCPG_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled point changed")

  // a visible point never has a negative coordinate
  `MCPG_ASSERT(a_vis_nonneg, clk, rst, m_tvalid && m_tuser[0] |-> !m_tdata[PIX_BITS-1] && !m_tdata[2*PIX_BITS-1], "visible point with negative coordinate")

  // reset empties the output register
  `MCPG_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind midpoint_circle_pixel_generator mcpg_checker #(
  .PIX_BITS     (COORD_BITS + 1),
  .OUT_DATA_BITS(((2*(COORD_BITS+1)+mcpg_pkg::COLOR_BITS+7)/8)*8)
) u_mcpg_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);

@@ tb/tb_midpoint_circle_pixel_generator.sv @@
`timescale 1ns / 1ps

module tb_midpoint_circle_pixel_generator;

  localparam int COORD_W     = 13;
  localparam int RAD_W       = 10;
  localparam int PIX_W       = COORD_W + 1;
  localparam int COLOR_W     = mcpg_pkg::COLOR_BITS;
  localparam int WIN_W       = mcpg_pkg::WIN_BITS;
  localparam int PWDATA_PAD  = mcpg_pkg::APB_DATA_BITS - WIN_W;
  localparam int S_DATA_W    = ((2*COORD_W + RAD_W + COLOR_W + 7) / 8) * 8;
  localparam int M_DATA_W    = ((2*PIX_W + COLOR_W + 7) / 8) * 8;
  // midpoint decision terms
  localparam int DEC_START   = 3;
  localparam int DEC_EAST    = 6;
  localparam int DEC_SOUTH   = 10;
  localparam int DEC_MULT    = 4;
  localparam int RANDOM_ITEMS = 400;
  // group reg + output reg, plus slack for a step taken while idle
  localparam int SETTLE_CYCLES = 16;
  // bound on the run: items x (8 points x worst stall + sender gap), with wide margin
  localparam int CYCLE_LIMIT = 400000;

  // one expected output point
  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COLOR_W-1:0]      color;
    logic                    vis;
    logic                    last;
    logic                    fin;
  } pixel_point_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [mcpg_pkg::APB_ADDR_BITS-1:0] paddr = '0;
  logic [mcpg_pkg::APB_DATA_BITS-1:0] pwdata = '0;
  logic [mcpg_pkg::APB_DATA_BITS-1:0] prdata;
  logic                      pready;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  // s_tdata, low bit up: center_x, center_y, radius, pen_color, zero pad
  logic [S_DATA_W-1:0]       s_tdata = '0;
  // s_tuser: start_req
  logic [0:0]                s_tuser = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // m_tdata, low bit up: pixel_x, pixel_y, pixel_color, zero pad
  logic [M_DATA_W-1:0]       m_tdata;
  logic                      m_tlast;
  // m_tuser, low bit up: visible, done_res
  logic [1:0]                m_tuser;

  // predictor state: window mirror and the circle in flight
  logic [WIN_W-1:0]          win_w = mcpg_pkg::WIN_WIDTH_RESET;
  logic [WIN_W-1:0]          win_h = mcpg_pkg::WIN_HEIGHT_RESET;
  bit                        circ_busy = 1'b0;
  int                        ctr_x = 0;
  int                        ctr_y = 0;
  int                        off_x = 0;
  int                        off_y = 0;
  int                        dec_val = 0;
  logic [COLOR_W-1:0]        pen = '0;

  pixel_point_t              expected_points[$];
  pixel_point_t              want_pt;
  int                        item_count = 0;   // items that produce a group
  int                        err_count = 0;
  int                        cycle_count = 0;
  int                        burst_left = 0;
  logic [7:0]                rdy_pattern = 8'hFF;
  logic [5:0]                rdy_phase = '0;

  midpoint_circle_pixel_generator #(
    .COORD_BITS (COORD_W),
    .RADIUS_BITS(RAD_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls: an eight-bit ready mask, redrawn each time the phase counter wraps.
  // Bit 0 always set so ready returns on every pass through the mask; 1 in 4 masks is all-ready.
  always @(posedge clk) begin
    if (rdy_phase == '0) begin
      rdy_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom_range(1, 255)) | 8'h01);
    end
    rdy_phase <= rdy_phase + 6'd1;
    m_tready  <= rdy_pattern[rdy_phase[2:0]];
  end

  // point checker: every output transfer against the oldest expected point
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point: x=%0d y=%0d", $signed(m_tdata[PIX_W-1:0]),
               $signed(m_tdata[2*PIX_W-1:PIX_W]));
        err_count++;
      end else begin
        want_pt = expected_points.pop_front();
        if (m_tdata[PIX_W-1:0] !== want_pt.x) begin
          $error("pixel_x: expected %0d, got %0d", want_pt.x, $signed(m_tdata[PIX_W-1:0]));
          err_count++;
        end
        if (m_tdata[2*PIX_W-1:PIX_W] !== want_pt.y) begin
          $error("pixel_y: expected %0d, got %0d", want_pt.y,
                 $signed(m_tdata[2*PIX_W-1:PIX_W]));
          err_count++;
        end
        if (m_tdata[2*PIX_W+COLOR_W-1:2*PIX_W] !== want_pt.color) begin
          $error("pixel_color: expected %h, got %h", want_pt.color,
                 m_tdata[2*PIX_W+COLOR_W-1:2*PIX_W]);
          err_count++;
        end
        if (m_tuser[0] !== want_pt.vis) begin
          $error("visible: expected %b, got %b", want_pt.vis, m_tuser[0]);
          err_count++;
        end
        if (m_tlast !== want_pt.last) begin
          $error("last: expected %b, got %b", want_pt.last, m_tlast);
          err_count++;
        end
        if (m_tuser[1] !== want_pt.fin) begin
          $error("done_res: expected %b, got %b", want_pt.fin, m_tuser[1]);
          err_count++;
        end
      end
    end
  end

  // eight mirrored points for the current offset, clipped to the window
  function automatic void push_group(input bit fin);
    int dx[8];
    int dy[8];
    int px;
    int py;
    pixel_point_t pt;
    dx = '{off_x, off_x, -off_x, -off_x, off_y, off_y, -off_y, -off_y};
    dy = '{off_y, -off_y, off_y, -off_y, off_x, -off_x, off_x, -off_x};
    for (int k = 0; k < 8; k++) begin
      px       = ctr_x + dx[k];
      py       = ctr_y + dy[k];
      pt.x     = PIX_W'(px);
      pt.y     = PIX_W'(py);
      pt.color = pen;
      pt.vis   = (px >= 0) && (py >= 0) && (px < int'(win_w)) && (py < int'(win_h));
      pt.last  = (k == 7);
      pt.fin   = fin;
      expected_points.push_back(pt);
    end
  endfunction

  function automatic void step_offsets();
    off_x++;
    if (dec_val < 0) begin
      dec_val = dec_val + off_x * DEC_MULT + DEC_EAST;
    end else begin
      dec_val = dec_val + (off_x - off_y) * DEC_MULT + DEC_SOUTH;
      off_y--;
    end
  endfunction

  // expected points for one accepted item
  function automatic void predict_item(input bit start, input logic signed [COORD_W-1:0] cx,
                                       input logic signed [COORD_W-1:0] cy,
                                       input logic [RAD_W-1:0] rad,
                                       input logic [COLOR_W-1:0] col);
    if (start) begin
      ctr_x     = cx;
      ctr_y     = cy;
      pen       = col;
      off_x     = 0;
      off_y     = rad;
      dec_val   = DEC_START - 2 * off_y;
      circ_busy = 1'b1;
      item_count++;
      push_group(1'b0);
      step_offsets();
    end else if (circ_busy) begin
      item_count++;
      if (off_x >= off_y) begin
        // final group; first group never gets here
        push_group(1'b1);
        circ_busy = 1'b0;
      end else begin
        push_group(1'b0);
        step_offsets();
      end
    end
  endfunction

  // one input transfer; sender runs in bursts with random gaps between them
  task automatic send_item(input bit start, input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy,
                           input logic [RAD_W-1:0] rad, input logic [COLOR_W-1:0] col);
    s_tuser  <= start;
    s_tdata  <= {{(S_DATA_W - 2*COORD_W - RAD_W - COLOR_W){1'b0}}, col, rad, cy, cx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_item(start, cx, cy, rad, col);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
    end
  endtask

  // step item; payload is ignored by the block, so fill it with noise
  task automatic send_step();
    send_item(1'b0, COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom),
              COLOR_W'($urandom));
  endtask

  // wait for every expected point, then let the pipeline settle
  task automatic drain_points();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, then idle; only called while drained
  task automatic write_window(input mcpg_pkg::reg_idx_t idx,
                              input logic [WIN_W-1:0] val, input bit junk_high);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk_high ? PWDATA_PAD'($urandom) : {PWDATA_PAD{1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == mcpg_pkg::REG_WINDOW_WIDTH) win_w = val;
    else win_h = val;
    @(posedge clk);
  endtask

  // mostly near the window so clipping cuts through circles, sometimes anywhere
  function automatic logic signed [COORD_W-1:0] pick_coord(input int lim);
    int v;
    if ($urandom_range(0, 3) == 0) return COORD_W'($urandom);
    v = $urandom_range(0, lim + 60);
    v = v - 30;
    if (v > 4095) v = 4095;
    return COORD_W'(v);
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WIN_W'(1);
      2: return WIN_W'(4096);
      3: return '1;
      default: return WIN_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // special cases at the reset window
  task automatic run_directed_circles();
    // zero radius: first group at (0,0) not done, next step is the final (1,-1) group
    send_item(1'b1, 13'sd0, 13'sd0, 10'd0, 16'h0000);
    send_step();
    send_step();                                    // idle: no points
    // field extremes, then abandoned by a new start while busy
    send_item(1'b1, -13'sd4096, 13'sd4095, 10'd1023, 16'hFFFF);
    send_step();
    send_step();
    send_item(1'b1, 13'sd4095, -13'sd4096, 10'd1, 16'h5A5A);
    while (circ_busy) send_step();
    // circle on the window corner, partly clipped
    send_item(1'b1, 13'sd639, 13'sd479, 10'd3, 16'h1234);
    while (circ_busy) send_step();
  endtask

  // window register extremes
  task automatic run_window_extremes();
    drain_points();
    write_window(mcpg_pkg::REG_WINDOW_WIDTH, '0, 1'b0);        // nothing visible
    write_window(mcpg_pkg::REG_WINDOW_HEIGHT, '0, 1'b0);
    send_item(1'b1, 13'sd1, 13'sd1, 10'd2, 16'hA5C3);
    while (circ_busy) send_step();
    drain_points();
    write_window(mcpg_pkg::REG_WINDOW_WIDTH, '1, 1'b0);        // oversized window
    write_window(mcpg_pkg::REG_WINDOW_HEIGHT, '1, 1'b0);
    send_item(1'b1, 13'sd4090, 13'sd4090, 10'd2, 16'h3C5A);
    while (circ_busy) send_step();
    drain_points();
    write_window(mcpg_pkg::REG_WINDOW_WIDTH, WIN_W'(1), 1'b0);   // single pixel
    write_window(mcpg_pkg::REG_WINDOW_HEIGHT, WIN_W'(1), 1'b0);
    send_item(1'b1, 13'sd0, 13'sd0, 10'd0, 16'h8001);
    send_step();
    drain_points();
    write_window(mcpg_pkg::REG_WINDOW_WIDTH, WIN_W'(4096), 1'b0);
    send_item(1'b1, 13'sd2048, 13'sd0, 10'd4, 16'h7FFE);
    while (circ_busy) send_step();
  endtask

  // random circles: mostly run to completion, some broken off by a new start,
  // with idle steps and window changes mixed in
  task automatic run_random_circles();
    int first_count;
    int episode;
    int rad;
    first_count = item_count;
    episode     = 0;
    while (item_count - first_count < RANDOM_ITEMS) begin
      if (episode % 10 == 0) begin
        drain_points();
        write_window(mcpg_pkg::REG_WINDOW_WIDTH, pick_window(), 1'b1);
        write_window(mcpg_pkg::REG_WINDOW_HEIGHT, pick_window(), 1'b1);
      end
      case ($urandom_range(0, 19))
        0, 1:    rad = $urandom_range(0, 1023);
        2, 3, 4: rad = $urandom_range(25, 120);
        default: rad = $urandom_range(0, 24);
      endcase
      send_item(1'b1, pick_coord(win_w), pick_coord(win_h), RAD_W'(rad),
                COLOR_W'($urandom));
      if (rad <= 120 && $urandom_range(0, 9) < 8) begin
        while (circ_busy) send_step();
      end else begin
        repeat ($urandom_range(0, 8)) send_step();
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_step();
      episode++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed_circles();
    run_window_extremes();
    run_random_circles();
    drain_points();
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
